/* src/shab_pkg.sv */
package shab_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       take_byte;   // write byte into the block buffer
      logic [7:0] fill_byte;   // byte value to write
      logic       count_byte;  // bump the message length
      logic       start_block; // copy hash words into round variables
      logic       do_round;    // run one round
      logic       fold;        // add round variables into hash words
      logic       reset_hash;  // restart hash and length for next message
      logic       load_out;    // load output register with part out_part
      logic [1:0] out_part;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [5:0] block_fill;
      logic [5:0] round_count;
      logic [63:0] bit_length;
   } dp_status_type;

   localparam logic [31:0] InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [5:0] LengthOffset = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* src/sha256_byte_stream_hasher_top.sv */
// SHA-256 hasher taking one message byte per item.
// A byte that does not complete a block is written to the block buffer; a byte
// that fills a 64-byte block also runs the one-round-per-cycle compressor.
// An end item pads one byte at a time, compressing each full block, then
// gives four 64-bit digest parts on consecutive cycles unless stalled.
// Synchronous reset restores the initial hash values and clears all counters.
module sha256_byte_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_part,
   output logic [1:0]  rsp_part_index,
   output logic        rsp_part_last
);

   shab_pkg::dp_cmd_type    cmd;
   shab_pkg::dp_status_type status;

   shab_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_message_end  (req_message_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_part_index   (rsp_part_index),
      .rsp_part_last    (rsp_part_last),
      .status           (status),
      .cmd              (cmd)
   );

   shab_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .part_data (rsp_digest_part)
   );

endmodule

/* src/shab_datapath.sv */
module shab_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  shab_pkg::dp_cmd_type   cmd,
   output shab_pkg::dp_status_type status,
   output logic [63:0]            part_data
);

   logic [31:0] hash_ff [8];
   logic [31:0] vars_ff [8];
   logic [31:0] win_ff [16];
   logic [63:0] len_ff;
   logic [5:0]  fill_ff;
   logic [5:0]  round_ff;
   logic [63:0] part_ff;

   logic [31:0] w_cur;
   logic [31:0] w15;
   logic [31:0] w2;
   logic [31:0] w_new;
   logic [31:0] t1;
   logic [31:0] t2;
   logic [3:0]  widx;
   logic [1:0]  bsel;

   assign widx = fill_ff[5:2];
   assign bsel = fill_ff[1:0];

   // Message schedule: first 16 rounds read the window, later ones extend it.
   always_comb begin
      w15 = win_ff[4'(round_ff[3:0] + 4'd1)];
      w2  = win_ff[4'(round_ff[3:0] + 4'd14)];
      w_new = win_ff[round_ff[3:0]]
         + (shab_pkg::rotr(w15, 7) ^ shab_pkg::rotr(w15, 18) ^ (w15 >> 3))
         + win_ff[4'(round_ff[3:0] + 4'd9)]
         + (shab_pkg::rotr(w2, 17) ^ shab_pkg::rotr(w2, 19) ^ (w2 >> 10));
      w_cur = (round_ff < 6'd16) ? win_ff[round_ff[3:0]] : w_new;
   end

   // One compression round.
   always_comb begin
      t1 = vars_ff[7]
         + (shab_pkg::rotr(vars_ff[4], 6) ^ shab_pkg::rotr(vars_ff[4], 11)
            ^ shab_pkg::rotr(vars_ff[4], 25))
         + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
         + shab_pkg::RoundK[round_ff] + w_cur;
      t2 = (shab_pkg::rotr(vars_ff[0], 2) ^ shab_pkg::rotr(vars_ff[0], 13)
            ^ shab_pkg::rotr(vars_ff[0], 22))
         + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
            ^ (vars_ff[1] & vars_ff[2]));
   end

   // Control counters and hash state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         round_ff <= '0;
         len_ff   <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= shab_pkg::InitHash[i];
      end else begin
         if (cmd.take_byte) fill_ff <= fill_ff + 6'd1;
         if (cmd.count_byte) len_ff <= len_ff + 64'd1;
         if (cmd.do_round) round_ff <= round_ff + 6'd1;
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + vars_ff[i];
         end
         if (cmd.reset_hash) begin
            len_ff <= '0;
            for (int i = 0; i < 8; i++) hash_ff[i] <= shab_pkg::InitHash[i];
         end
      end
   end

   // Block buffer, round variables and output word.
   always_ff @(posedge clock) begin
      if (cmd.take_byte) begin
         unique case (bsel)
            2'd0: win_ff[widx] <= {cmd.fill_byte, 24'd0};
            2'd1: win_ff[widx][23:16] <= cmd.fill_byte;
            2'd2: win_ff[widx][15:8] <= cmd.fill_byte;
            default: win_ff[widx][7:0] <= cmd.fill_byte;
         endcase
      end
      if (cmd.start_block) begin
         for (int i = 0; i < 8; i++) vars_ff[i] <= hash_ff[i];
      end
      if (cmd.do_round) begin
         if (round_ff >= 6'd16) win_ff[round_ff[3:0]] <= w_new;
         vars_ff[7] <= vars_ff[6];
         vars_ff[6] <= vars_ff[5];
         vars_ff[5] <= vars_ff[4];
         vars_ff[4] <= vars_ff[3] + t1;
         vars_ff[3] <= vars_ff[2];
         vars_ff[2] <= vars_ff[1];
         vars_ff[1] <= vars_ff[0];
         vars_ff[0] <= t1 + t2;
      end
      if (cmd.load_out) begin
         part_ff <= {hash_ff[{cmd.out_part, 1'b0}], hash_ff[{cmd.out_part, 1'b1}]};
      end
   end

   assign status.block_fill  = fill_ff;
   assign status.round_count = round_ff;
   assign status.bit_length  = {len_ff[60:0], 3'b000};
   assign part_data = part_ff;

endmodule

/* src/shab_controller.sv */
module shab_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_byte_present,
   input  logic                    req_message_end,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_part_index,
   output logic                    rsp_part_last,
   input  shab_pkg::dp_status_type status,
   output shab_pkg::dp_cmd_type    cmd
);

   shab_pkg::ctrl_state_type state_ff, state_in;
   logic       fin_ff, fin_in;     // padding is in progress
   logic       pad_ff, pad_in;     // 0x80 byte already written
   logic       len_phase_ff, len_phase_in; // length bytes are being written
   logic [1:0] part_ff, part_in;
   logic       out_valid_ff, out_valid_in;
   logic       accept;
   logic       out_take;
   logic [5:0] len_pos;

   assign req_stall = (state_ff != shab_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign len_pos   = status.block_fill - shab_pkg::LengthOffset;

   // Next state.
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      pad_in       = pad_ff;
      len_phase_in = len_phase_ff;
      part_in      = part_ff;
      out_valid_in = out_valid_ff;
      if (out_take) out_valid_in = 1'b0;
      unique case (state_ff)
         shab_pkg::ST_IDLE: begin
            if (accept) begin
               fin_in = req_message_end;
               pad_in = 1'b0;
               len_phase_in = 1'b0;
               if (req_byte_present) state_in = shab_pkg::ST_LOAD;
               else if (req_message_end) state_in = shab_pkg::ST_PAD;
            end
         end
         shab_pkg::ST_LOAD: begin
            // One byte was written; a full block starts the rounds.
            if (status.block_fill == 6'd0) state_in = shab_pkg::ST_ROUND;
            else if (fin_ff) state_in = shab_pkg::ST_PAD;
            else state_in = shab_pkg::ST_IDLE;
         end
         shab_pkg::ST_ROUND: begin
            if (status.round_count == 6'd63) state_in = shab_pkg::ST_FOLD;
         end
         shab_pkg::ST_FOLD: begin
            if (fin_ff) state_in = shab_pkg::ST_PAD;
            else state_in = shab_pkg::ST_IDLE;
         end
         shab_pkg::ST_PAD: begin
            // Zero padding stops once the fill reaches the length offset.
            if (!pad_ff) pad_in = 1'b1;
            else if (status.block_fill == shab_pkg::LengthOffset) len_phase_in = 1'b1;
            if (len_phase_ff && status.block_fill == 6'd0) begin
               // Length block just finished: emit the digest.
               state_in = shab_pkg::ST_EMIT;
               part_in  = 2'd0;
            end else begin
               state_in = shab_pkg::ST_LOAD;
            end
         end
         shab_pkg::ST_EMIT: begin
            if (!out_valid_ff || out_take) begin
               out_valid_in = 1'b1;
               part_in = part_ff + 2'd1;
               if (part_ff == 2'd3) begin
                  state_in = shab_pkg::ST_IDLE;
                  fin_in = 1'b0;
               end
            end
         end
         default: state_in = shab_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         shab_pkg::ST_IDLE: begin
            if (accept && req_byte_present) begin
               cmd.take_byte  = 1'b1;
               cmd.fill_byte  = req_data_byte;
               cmd.count_byte = 1'b1;
            end
         end
         shab_pkg::ST_LOAD: begin
            if (status.block_fill == 6'd0) cmd.start_block = 1'b1;
         end
         shab_pkg::ST_ROUND: cmd.do_round = 1'b1;
         shab_pkg::ST_FOLD: cmd.fold = 1'b1;
         shab_pkg::ST_PAD: begin
            if (!(len_phase_ff && status.block_fill == 6'd0)) begin
               cmd.take_byte = 1'b1;
               if (!pad_ff) cmd.fill_byte = shab_pkg::PadByte;
               else if (len_phase_ff || status.block_fill == shab_pkg::LengthOffset)
                  cmd.fill_byte = status.bit_length[8 * (7 - len_pos[2:0]) +: 8];
               else cmd.fill_byte = 8'd0;
            end
         end
         shab_pkg::ST_EMIT: begin
            if (!out_valid_ff || out_take) begin
               cmd.load_out = 1'b1;
               cmd.out_part = part_ff;
               if (part_ff == 2'd3) cmd.reset_hash = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // Result tag registers follow the datapath output word.
   logic [1:0] idx_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shab_pkg::ST_IDLE;
         fin_ff       <= 1'b0;
         pad_ff       <= 1'b0;
         len_phase_ff <= 1'b0;
         part_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         pad_ff       <= pad_in;
         len_phase_ff <= len_phase_in;
         part_ff      <= part_in;
         out_valid_ff <= out_valid_in;
      end
      if (cmd.load_out) idx_ff <= cmd.out_part;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_part_index = idx_ff;
   assign rsp_part_last  = (idx_ff == 2'd3);

endmodule
